>>> sv/msa_pkg.sv
// Shared types and codes for the memory share slot allocator.
// Holds the item and result structs, item kinds and register indexes.
// No dependencies.
package msa_pkg;

	localparam int BYTES_W = 40;
	localparam int TOT_W = 48;
	localparam int TIME_W = 48;
	localparam int CNT_W = 32;
	localparam int TASK_W = 11;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] KIND_REGISTER = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_SLOT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MEM_BUDGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OPERATOR_CAP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TASKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TASKS = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_INTERVAL = 3'd6;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] operator_id;
		logic [BYTES_W-1:0] sample_bytes;
		logic [5:0] instance_index;
		logic [TIME_W-1:0] now_ms;
	} msa_item_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_slots;
		logic [BYTES_W-1:0] operator_limit;
	} msa_result_t;

endpackage

>>> sv/memory_share_slot_allocator.sv
// Memory share slot allocator: per-operator block size averages and proportional limits.
// One shift-add multiplier and one restoring divider, one bit per cycle; depends on msa_pkg.
// A slot request runs at most two 40-step divides, one 40-step multiply and one
// 80-step divide. One item at a time; the next item can start in the cycle of the
// result strobe, and the receiver cannot stall. Reset restores the register defaults
// at once and clears the control state and per-operator tables, not the datapath registers.
module memory_share_slot_allocator import msa_pkg::*; #(
	parameter int NUM_OPERATORS = 16,
	parameter logic [39:0] DEFAULT_BLOCK_BYTES = 40'd1048576
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input msa_item_t item,
	output logic done,
	output msa_result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [BYTES_W-1:0] cfg_data
);

	localparam int OP_W = (NUM_OPERATORS > 1) ? $clog2(NUM_OPERATORS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_MUL_A, ST_ADDV, ST_DIV_A, ST_UPD_A, ST_DIV_M, ST_LOADP,
		ST_DIV_P, ST_SLOTS, ST_REPORT, ST_LIMIT, ST_MUL_L, ST_LOADL, ST_DIV_L, ST_SETL,
		ST_TIME, ST_FINISH
	} state_t;

	state_t state_q;
	logic [6:0] step_q;
	logic done_q;
	msa_result_t result_q;

	logic [BYTES_W-1:0] budget_q, cap_q;
	logic [6:0] inst_q;
	logic serial_q;
	logic [TASK_W-1:0] min_q, max_q;
	logic [15:0] interval_q;

	logic signed [TOT_W-1:0] total_q;
	logic [BYTES_W-1:0] avg_q [NUM_OPERATORS];
	logic [CNT_W-1:0] samp_q [NUM_OPERATORS];
	logic [BYTES_W-1:0] rep_q [NUM_OPERATORS];
	logic [BYTES_W-1:0] lim_q [NUM_OPERATORS];
	logic [TASK_W-1:0] exp_q [NUM_OPERATORS];
	logic [TIME_W-1:0] last_q [NUM_OPERATORS];

	logic [1:0] kind_q;
	logic [OP_W-1:0] op_q;
	logic op_ok_q;
	logic [BYTES_W-1:0] sample_q;
	logic [5:0] idx_q;
	logic [TIME_W-1:0] now_q;
	logic [BYTES_W-1:0] v_q, nv_q, mul_a_q, quo_q;
	logic [2*BYTES_W-1:0] prod_q, dvd_q;
	logic [TOT_W-1:0] dvs_q, rem_q, den_q;
	logic [TASK_W-1:0] hit_q;

	logic accept;
	logic [BYTES_W-1:0] avg_rd, lim_rd, rep_rd, nv;
	logic [CNT_W-1:0] samp_rd;
	logic [CNT_W:0] n1;
	logic [BYTES_W:0] msum;
	logic [TOT_W:0] r_sh;
	logic q_bit;
	logic [BYTES_W-1:0] m_val;
	logic [6:0] p_val;
	logic [BYTES_W:0] slots;
	logic [TASK_W-1:0] lo_t, new_exp;
	logic signed [TOT_W+1:0] t_reg, t_rep;
	logic [TIME_W+1:0] tdiff;
	logic late;

	function automatic logic signed [TOT_W-1:0] sat_total(input logic signed [TOT_W+1:0] t);
		logic signed [TOT_W-1:0] r;
		if (!t[TOT_W+1] && t[TOT_W:TOT_W-1] != 2'b00) begin
			r = {1'b0, {(TOT_W-1){1'b1}}};
		end else if (t[TOT_W+1] && t[TOT_W:TOT_W-1] != 2'b11) begin
			r = {1'b1, {(TOT_W-1){1'b0}}};
		end else begin
			r = t[TOT_W-1:0];
		end
		return r;
	endfunction

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		avg_rd = avg_q[op_q];
		lim_rd = lim_q[op_q];
		rep_rd = rep_q[op_q];
		samp_rd = samp_q[op_q];
		n1 = {1'b0, samp_rd} + {{CNT_W{1'b0}}, 1'b1};
		nv = (avg_rd > cap_q) ? cap_q : avg_rd;
		msum = {1'b0, prod_q[2*BYTES_W-1:BYTES_W]} + (prod_q[0] ? {1'b0, mul_a_q} : '0);
		r_sh = {rem_q, dvd_q[2*BYTES_W-1]};
		q_bit = (r_sh >= {1'b0, dvs_q});
		m_val = (quo_q == '0) ? {{(BYTES_W-1){1'b0}}, 1'b1} : quo_q;
		p_val = (inst_q == '0) ? 7'd1 : inst_q;
		if (avg_rd == '0) begin
			slots = {{BYTES_W{1'b0}}, 1'b1};
		end else if (serial_q) begin
			slots = {1'b0, quo_q} + {{(BYTES_W-6){1'b0}}, rem_q[6:0]};
		end else begin
			slots = {1'b0, quo_q} + {{BYTES_W{1'b0}}, ({1'b0, idx_q} < rem_q[6:0])};
		end
		lo_t = (min_q == '0) ? {{(TASK_W-1){1'b0}}, 1'b1} : min_q;
		new_exp = (hit_q > lo_t) ? hit_q : lo_t;
		t_reg = {{2{total_q[TOT_W-1]}}, total_q} + {10'b0, DEFAULT_BLOCK_BYTES};
		t_rep = {{2{total_q[TOT_W-1]}}, total_q} + {10'b0, nv} - {10'b0, rep_rd};
		tdiff = {2'b00, now_q} - {2'b00, last_q[op_q]};
		late = !tdiff[TIME_W+1] && (tdiff[TIME_W:0] > {33'b0, interval_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (kind_q == KIND_REGISTER || !op_ok_q) begin
						state_q <= ST_FINISH;
					end else if (kind_q == KIND_SAMPLE && sample_q != '0) begin
						state_q <= ST_MUL_A;
					end else if (kind_q == KIND_SLOT) begin
						state_q <= (avg_rd == '0) ? ST_SLOTS : ST_DIV_M;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_MUL_A: begin
					if (step_q == 7'(BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_ADDV;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_ADDV: state_q <= ST_DIV_A;
				ST_DIV_A: begin
					if (step_q == 7'(2 * BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_UPD_A;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_UPD_A: state_q <= ST_FINISH;
				ST_DIV_M: begin
					if (step_q == 7'(BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_LOADP;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_LOADP: state_q <= ST_DIV_P;
				ST_DIV_P: begin
					if (step_q == 7'(BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_SLOTS;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_SLOTS: state_q <= (idx_q == '0) ? ST_REPORT : ST_TIME;
				ST_REPORT: state_q <= (nv == '0) ? ST_TIME : ST_LIMIT;
				ST_LIMIT: begin
					if (total_q[TOT_W-1] || total_q == '0) state_q <= ST_TIME;
					else state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					if (step_q == 7'(BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_LOADL;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_LOADL: state_q <= ST_DIV_L;
				ST_DIV_L: begin
					if (step_q == 7'(2 * BYTES_W - 1)) begin
						step_q <= '0;
						state_q <= ST_SETL;
					end else begin
						step_q <= step_q + 7'd1;
					end
				end
				ST_SETL: state_q <= ST_TIME;
				ST_TIME: state_q <= ST_FINISH;
				ST_FINISH: begin
					if (!op_ok_q) begin
						result_q <= '0;
					end else begin
						result_q.task_slots <= (kind_q == KIND_SLOT) ? exp_q[op_q] : '0;
						result_q.operator_limit <= lim_rd;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= 40'd1073741824;
			cap_q <= 40'd1073741824;
			inst_q <= 7'd1;
			serial_q <= 1'b0;
			min_q <= 11'd1;
			max_q <= 11'd1024;
			interval_q <= 16'd100;
			total_q <= '0;
			for (int i = 0; i < NUM_OPERATORS; i++) begin
				avg_q[i] <= '0;
				samp_q[i] <= '0;
				rep_q[i] <= '0;
				lim_q[i] <= '0;
				exp_q[i] <= 11'd1;
				last_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MEM_BUDGET: budget_q <= cfg_data;
					CFG_OPERATOR_CAP: cap_q <= cfg_data;
					CFG_INSTANCE_COUNT: inst_q <= cfg_data[6:0];
					CFG_SERIAL_MODE: serial_q <= cfg_data[0];
					CFG_MIN_TASKS: min_q <= cfg_data[TASK_W-1:0];
					CFG_MAX_TASKS: max_q <= cfg_data[TASK_W-1:0];
					CFG_ADJUST_INTERVAL: interval_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_DECODE: begin
					if (kind_q == KIND_REGISTER) total_q <= sat_total(t_reg);
				end
				ST_UPD_A: begin
					avg_q[op_q] <= quo_q;
					samp_q[op_q] <= n1[CNT_W] ? {CNT_W{1'b1}} : n1[CNT_W-1:0];
				end
				ST_REPORT: begin
					total_q <= sat_total(t_rep);
					rep_q[op_q] <= nv;
					if (nv == '0) lim_q[op_q] <= '0;
				end
				ST_LIMIT: begin
					if (total_q[TOT_W-1] || total_q == '0) lim_q[op_q] <= budget_q;
				end
				ST_SETL: lim_q[op_q] <= quo_q;
				ST_TIME: begin
					if (late) begin
						last_q[op_q] <= now_q;
						exp_q[op_q] <= new_exp;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= item.kind;
					op_q <= OP_W'(item.operator_id);
					op_ok_q <= (32'(item.operator_id) < NUM_OPERATORS);
					sample_q <= item.sample_bytes;
					idx_q <= item.instance_index;
					now_q <= item.now_ms;
				end
			end
			ST_DECODE: begin
				v_q <= (sample_q < cap_q) ? sample_q : cap_q;
				mul_a_q <= avg_rd;
				prod_q <= {{(2*BYTES_W-CNT_W){1'b0}}, samp_rd};
				dvd_q <= {lim_rd, {BYTES_W{1'b0}}};
				dvs_q <= {{(TOT_W-BYTES_W){1'b0}}, avg_rd};
				rem_q <= '0;
			end
			ST_MUL_A, ST_MUL_L: begin
				prod_q <= {msum, prod_q[BYTES_W-1:1]};
			end
			ST_ADDV: begin
				dvd_q <= prod_q + {{BYTES_W{1'b0}}, v_q};
				dvs_q <= {{(TOT_W-CNT_W-1){1'b0}}, n1};
				rem_q <= '0;
			end
			ST_DIV_A, ST_DIV_M, ST_DIV_P, ST_DIV_L: begin
				rem_q <= q_bit ? TOT_W'(r_sh - {1'b0, dvs_q}) : r_sh[TOT_W-1:0];
				quo_q <= {quo_q[BYTES_W-2:0], q_bit};
				dvd_q <= {dvd_q[2*BYTES_W-2:0], 1'b0};
			end
			ST_LOADP: begin
				dvd_q <= {m_val, {BYTES_W{1'b0}}};
				dvs_q <= {{(TOT_W-7){1'b0}}, p_val};
				rem_q <= '0;
			end
			ST_SLOTS: begin
				hit_q <= (slots > {{(BYTES_W-TASK_W+1){1'b0}}, max_q}) ? max_q
					: slots[TASK_W-1:0];
			end
			ST_REPORT: nv_q <= nv;
			ST_LIMIT: begin
				mul_a_q <= budget_q;
				prod_q <= {{BYTES_W{1'b0}}, nv_q};
				den_q <= (total_q > $signed({{(TOT_W-BYTES_W){1'b0}}, nv_q}))
					? total_q : {{(TOT_W-BYTES_W){1'b0}}, nv_q};
			end
			ST_LOADL: begin
				dvd_q <= prod_q;
				dvs_q <= den_q;
				rem_q <= '0;
			end
			default: ;
		endcase
	end

endmodule
